>>> sv/prsa_pkg.sv
// ----------------------------------------------------------------------------
// prsa_pkg
// Shared types and constants of the packed record slot allocator.
// ----------------------------------------------------------------------------
package prsa_pkg;

	localparam int NUM_RECORDS = 16;
	localparam int IDX_W = (NUM_RECORDS > 1) ? $clog2(NUM_RECORDS) : 1;
	localparam int ID_W = 4;
	localparam int SIZE_W = 8;
	localparam int ADDR_W = 16;
	localparam int CMP_W = ((IDX_W > ID_W) ? IDX_W : ID_W) + 1;
	localparam int ROOM_W = ADDR_W + 2;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [ADDR_W-1:0] TOP_RESET = 16'd255;

	localparam logic CMD_PLACE = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_REFUSED = 1'b1;

	localparam logic REG_TOP_ADDRESS = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE
	} prsa_state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic finish;
	} prsa_cmd_t;

	typedef struct packed {
		logic scan_last;
	} prsa_sts_t;

endpackage

>>> sv/prsa_regs.sv
// ----------------------------------------------------------------------------
// prsa_regs
// Configuration register file with the APB-style access port.
// ----------------------------------------------------------------------------
module prsa_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [prsa_pkg::PADDR_W-1:0]        paddr,
	input  logic [prsa_pkg::PDATA_W-1:0]        pwdata,
	output logic [prsa_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready,
	output logic [prsa_pkg::ADDR_W-1:0]         top_address
);

	logic [prsa_pkg::ADDR_W-1:0] top_q;
	logic wr_en;
	logic sel_top;

	assign pready = 1'b1;
	assign sel_top = (paddr[2] == prsa_pkg::REG_TOP_ADDRESS);
	assign wr_en = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= prsa_pkg::TOP_RESET;
		end else if (wr_en && sel_top) begin
			top_q <= pwdata[prsa_pkg::ADDR_W-1:0];
		end
	end

	always_comb begin
		if (sel_top) begin
			prdata = {{(prsa_pkg::PDATA_W - prsa_pkg::ADDR_W){1'b0}}, top_q};
		end else begin
			prdata = '0;
		end
	end

	assign top_address = top_q;

endmodule

>>> sv/prsa_ctrl.sv
// ----------------------------------------------------------------------------
// prsa_ctrl
// Controller state machine that sequences the table scan and the decision.
// ----------------------------------------------------------------------------
module prsa_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  prsa_pkg::prsa_sts_t   sts,
	output prsa_pkg::prsa_cmd_t   cmd,
	output logic                  busy
);

	prsa_pkg::prsa_state_t state_q;
	prsa_pkg::prsa_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prsa_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			prsa_pkg::ST_IDLE: begin
				if (start) state_nxt = prsa_pkg::ST_SCAN;
			end
			prsa_pkg::ST_SCAN: begin
				if (sts.scan_last) state_nxt = prsa_pkg::ST_DRAIN;
			end
			prsa_pkg::ST_DRAIN: state_nxt = prsa_pkg::ST_DECIDE;
			prsa_pkg::ST_DECIDE: state_nxt = prsa_pkg::ST_IDLE;
			default: state_nxt = prsa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			prsa_pkg::ST_IDLE: begin
				busy = 1'b0;
				cmd.load = start;
			end
			prsa_pkg::ST_SCAN: cmd.scan = 1'b1;
			prsa_pkg::ST_DRAIN: cmd = '0;
			prsa_pkg::ST_DECIDE: cmd.finish = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

>>> sv/prsa_dp.sv
// ----------------------------------------------------------------------------
// prsa_dp
// Datapath: size table memory, running base sum, refusal checks and results.
// ----------------------------------------------------------------------------
module prsa_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  prsa_pkg::prsa_cmd_t               cmd,
	output prsa_pkg::prsa_sts_t               sts,
	input  logic [prsa_pkg::ADDR_W-1:0]       top_address,
	input  logic                              in_cmd,
	input  logic [prsa_pkg::ID_W-1:0]         in_id,
	input  logic [prsa_pkg::SIZE_W-1:0]       in_size,
	output logic                              done,
	output logic                              status,
	output logic [prsa_pkg::ADDR_W-1:0]       base_address,
	output logic [prsa_pkg::SIZE_W-1:0]       stored_size
);

	logic [prsa_pkg::SIZE_W-1:0] mem [prsa_pkg::NUM_RECORDS];
	logic [prsa_pkg::NUM_RECORDS-1:0] vld_q;

	logic cmd_q;
	logic [prsa_pkg::ID_W-1:0] id_q;
	logic [prsa_pkg::SIZE_W-1:0] size_q;
	logic [prsa_pkg::IDX_W-1:0] idx_q;
	logic [prsa_pkg::ADDR_W-1:0] sum_q;
	logic [prsa_pkg::SIZE_W-1:0] prev_q;
	logic [prsa_pkg::SIZE_W-1:0] cur_q;

	logic rd_vld_s1;
	logic [prsa_pkg::IDX_W-1:0] idx_s1;
	logic [prsa_pkg::SIZE_W-1:0] rd_data_s1;

	logic done_q;
	logic status_q;
	logic [prsa_pkg::ADDR_W-1:0] base_q;
	logic [prsa_pkg::SIZE_W-1:0] stored_q;

	logic in_table;
	logic [prsa_pkg::IDX_W-1:0] last_idx;
	logic [prsa_pkg::IDX_W-1:0] wr_idx;
	logic no_room;
	logic refuse;
	logic do_write;

	assign in_table = prsa_pkg::CMP_W'(id_q) < prsa_pkg::CMP_W'(prsa_pkg::NUM_RECORDS);
	assign wr_idx = prsa_pkg::IDX_W'(id_q);
	assign last_idx = in_table ? wr_idx : prsa_pkg::IDX_W'(prsa_pkg::NUM_RECORDS - 1);
	assign sts.scan_last = (idx_q == last_idx);

	assign no_room = (prsa_pkg::ROOM_W'(sum_q) + prsa_pkg::ROOM_W'(size_q)
		+ prsa_pkg::ROOM_W'(id_q)) > prsa_pkg::ROOM_W'(top_address);
	assign refuse = !in_table || (size_q == '0) || ((id_q != '0) && (prev_q == '0))
		|| no_room;
	assign do_write = cmd.finish && (cmd_q == prsa_pkg::CMD_PLACE) && !refuse
		&& (cur_q == '0);

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[wr_idx] <= size_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			rd_data_s1 <= vld_q[idx_q] ? mem[idx_q] : '0;
			idx_s1 <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan;
			done_q <= cmd.finish;
			if (do_write) begin
				vld_q[wr_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_cmd;
			id_q <= in_id;
			size_q <= in_size;
			idx_q <= '0;
			sum_q <= '0;
			prev_q <= '0;
			cur_q <= '0;
		end else begin
			if (cmd.scan) begin
				idx_q <= idx_q + 1'b1;
			end
			if (rd_vld_s1) begin
				if (prsa_pkg::CMP_W'(idx_s1) < prsa_pkg::CMP_W'(id_q)) begin
					sum_q <= sum_q + prsa_pkg::ADDR_W'(rd_data_s1);
					prev_q <= rd_data_s1;
				end else if (prsa_pkg::CMP_W'(idx_s1) == prsa_pkg::CMP_W'(id_q)) begin
					cur_q <= rd_data_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			base_q <= sum_q;
			if ((cmd_q == prsa_pkg::CMD_PLACE) && refuse) begin
				status_q <= prsa_pkg::STATUS_REFUSED;
			end else begin
				status_q <= prsa_pkg::STATUS_OK;
			end
			stored_q <= do_write ? size_q : cur_q;
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign base_address = base_q;
	assign stored_size = stored_q;

`ifndef ASSERT_OFF
	a_no_read_at_decide: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !rd_vld_s1)
		else $error("A table read is still in flight at the decision.");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> (prsa_pkg::CMP_W'(idx_q) <= prsa_pkg::CMP_W'(last_idx)))
		else $error("The scan index ran past the last entry.");

	a_place_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (cmd_q == prsa_pkg::CMD_PLACE) && (status_q == prsa_pkg::STATUS_OK))
		|-> (stored_q != '0))
		else $error("A successful place left an empty slot.");

	a_write_keeps_valid: assert property (@(posedge clk) disable iff (!arst_n)
		do_write |=> vld_q[$past(wr_idx)])
		else $error("A written slot is not marked valid.");
`endif

endmodule

>>> sv/packed_record_slot_allocator.sv
// ----------------------------------------------------------------------------
// packed_record_slot_allocator
// Size table of packed records with place and lookup commands.
// ----------------------------------------------------------------------------
// A command transaction is taken at a rising edge where start is high and
// busy is low; cmd, item_id and item_size are sampled at that edge. A place
// command stores a nonzero item_size for the id if the slot is empty, the
// slot below it is filled (for ids above 0) and base + size + id does not
// exceed top_address; a lookup returns the base address and stored size.
// Every transaction yields one result on status, base_address and
// stored_size, marked by done for exactly one cycle; there is no back
// pressure on results. The base address is summed from the size table, one
// entry per cycle read from a single-port table memory. A command for id n
// scans entries 0 to n, then the drain and decide states before done is
// registered; busy drops in the cycle that done is shown, so the next
// command can be taken at the edge that ends it. The top_address register
// is written and read over the APB-style port; the user must write it only
// while the block is idle, which the block does not enforce. Reset clears
// the size table to empty, sets top_address to 255 and returns the
// controller to idle with no result pending.
// ----------------------------------------------------------------------------
module packed_record_slot_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [prsa_pkg::PADDR_W-1:0]      paddr,
	input  logic [prsa_pkg::PDATA_W-1:0]      pwdata,
	output logic [prsa_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	input  logic                              start,
	output logic                              busy,
	input  logic                              cmd,
	input  logic [prsa_pkg::ID_W-1:0]         item_id,
	input  logic [prsa_pkg::SIZE_W-1:0]       item_size,
	output logic                              done,
	output logic                              status,
	output logic [prsa_pkg::ADDR_W-1:0]       base_address,
	output logic [prsa_pkg::SIZE_W-1:0]       stored_size
);

	logic [prsa_pkg::ADDR_W-1:0] top_address;
	prsa_pkg::prsa_cmd_t ctl_cmd;
	prsa_pkg::prsa_sts_t dp_sts;

	prsa_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.top_address (top_address)
	);

	prsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (dp_sts),
		.cmd    (ctl_cmd),
		.busy   (busy)
	);

	prsa_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (ctl_cmd),
		.sts          (dp_sts),
		.top_address  (top_address),
		.in_cmd       (cmd),
		.in_id        (item_id),
		.in_size      (item_size),
		.done         (done),
		.status       (status),
		.base_address (base_address),
		.stored_size  (stored_size)
	);

endmodule
